// ----- sv/fla_pkg.sv -----
package fla_pkg;

  localparam int IDX_W            = 13;
  localparam int BYTES_W          = 16;
  localparam int NEED_W           = BYTES_W + 1;
  localparam int ARENA_UNITS_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 16;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t rd_addr;
    logic sz_we;
    idx_t sz_waddr;
    idx_t sz_wdata;
    logic nx_we;
    idx_t nx_waddr;
    idx_t nx_wdata;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_FIRST,
    ST_A_WALK,
    ST_A_SPLIT2,
    ST_F_WALK,
    ST_F_RDNX,
    ST_F_RDBP,
    ST_F_LOWER,
    ST_DONE
  } state_t;

endpackage

// ----- sv/fla_store.sv -----
module fla_store #(
  parameter int ARENA_UNITS = fla_pkg::ARENA_UNITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fla_pkg::mem_req_t req,
  output fla_pkg::idx_t    sz_rd,
  output fla_pkg::idx_t    nx_rd
);

  localparam int DEPTH = ARENA_UNITS + 1;
  localparam int AW    = $clog2(DEPTH);

  fla_pkg::idx_t size_mem [DEPTH];
  fla_pkg::idx_t next_mem [DEPTH];

  fla_pkg::idx_t sz_raw_r;
  fla_pkg::idx_t nx_raw_r;
  fla_pkg::idx_t rd_addr_r;
  logic [1:0]    sz_vld_r;
  logic [1:0]    nx_vld_r;
  logic [1:0]    sz_vld_nxt;
  logic [1:0]    nx_vld_nxt;

  always_ff @(posedge clk) begin
    if (req.sz_we) begin
      size_mem[req.sz_waddr[AW-1:0]] <= req.sz_wdata;
    end
    if (req.nx_we) begin
      next_mem[req.nx_waddr[AW-1:0]] <= req.nx_wdata;
    end
    sz_raw_r  <= size_mem[req.rd_addr[AW-1:0]];
    nx_raw_r  <= next_mem[req.rd_addr[AW-1:0]];
    rd_addr_r <= req.rd_addr;
  end

  // entries 0 and 1 read as their reset values until written
  always_comb begin
    sz_vld_nxt = sz_vld_r;
    nx_vld_nxt = nx_vld_r;
    if (req.sz_we && req.sz_waddr == fla_pkg::idx_t'(0)) sz_vld_nxt[0] = 1'b1;
    if (req.sz_we && req.sz_waddr == fla_pkg::idx_t'(1)) sz_vld_nxt[1] = 1'b1;
    if (req.nx_we && req.nx_waddr == fla_pkg::idx_t'(0)) nx_vld_nxt[0] = 1'b1;
    if (req.nx_we && req.nx_waddr == fla_pkg::idx_t'(1)) nx_vld_nxt[1] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sz_vld_r <= 2'b00;
      nx_vld_r <= 2'b00;
    end else begin
      sz_vld_r <= sz_vld_nxt;
      nx_vld_r <= nx_vld_nxt;
    end
  end

  always_comb begin
    sz_rd = sz_raw_r;
    nx_rd = nx_raw_r;
    if (rd_addr_r == fla_pkg::idx_t'(0)) begin
      if (!sz_vld_r[0]) sz_rd = '0;
      if (!nx_vld_r[0]) nx_rd = fla_pkg::idx_t'(1);
    end else if (rd_addr_r == fla_pkg::idx_t'(1)) begin
      if (!sz_vld_r[1]) sz_rd = fla_pkg::idx_t'(ARENA_UNITS);
      if (!nx_vld_r[1]) nx_rd = '0;
    end
  end

endmodule

// ----- sv/fla_ctrl.sv -----
module fla_ctrl #(
  parameter int ARENA_UNITS  = fla_pkg::ARENA_UNITS_DEF,
  parameter int HEADER_BYTES = fla_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [fla_pkg::BYTES_W-1:0]    request_bytes,
  input  fla_pkg::idx_t                  block_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fla_pkg::idx_t                  granted_address,
  output logic                           alloc_failed,
  output fla_pkg::mem_req_t              req,
  input  fla_pkg::idx_t                  sz_rd,
  input  fla_pkg::idx_t                  nx_rd
);

  localparam int W1       = fla_pkg::IDX_W + 1;
  localparam int STEP_W   = $clog2(ARENA_UNITS + 3) + 1;
  localparam int SH       = fla_pkg::NEED_W + $clog2(HEADER_BYTES);
  localparam longint RECIP = ((longint'(1) << SH) + HEADER_BYTES - 1) / HEADER_BYTES;
  localparam int RECIP_W  = SH + 1;
  localparam int PROD_W   = fla_pkg::NEED_W + RECIP_W;

  fla_pkg::state_t state_r, state_nxt;
  fla_pkg::idx_t rover_r, rover_nxt, prev_r, prev_nxt, p_r, p_nxt, bp_r, bp_nxt;
  fla_pkg::idx_t nx_r, nx_nxt, szp_r, szp_nxt, sznx_r, sznx_nxt, nxnx_r, nxnx_nxt;
  fla_pkg::idx_t newsz_r, newsz_nxt, newnext_r, newnext_nxt, q_r, q_nxt;
  fla_pkg::idx_t grant_r, grant_nxt, out_addr_r, out_addr_nxt;
  logic fail_r, fail_nxt, out_fail_r, out_fail_nxt, out_valid_r, out_valid_nxt;
  logic [fla_pkg::NEED_W-1:0] need_r, need_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;

  logic [fla_pkg::NEED_W-1:0] bytes_up;
  logic [PROD_W-1:0]          prod;
  fla_pkg::idx_t              lk, rest;
  logic [W1-1:0]              qsum, upsum, losum;
  logic                       last_step;

  function automatic fla_pkg::idx_t link(fla_pkg::idx_t x);
    return (W1'(x) <= W1'(ARENA_UNITS)) ? x : '0;
  endfunction

  assign bytes_up  = fla_pkg::NEED_W'(request_bytes) + fla_pkg::NEED_W'(HEADER_BYTES - 1);
  assign prod      = PROD_W'(bytes_up) * PROD_W'(RECIP);
  assign lk        = link(nx_rd);
  assign rest      = fla_pkg::idx_t'(fla_pkg::NEED_W'(sz_rd) - need_r);
  assign qsum      = W1'(p_r) + W1'(rest);
  assign upsum     = W1'(bp_r) + W1'(sz_rd);
  assign losum     = W1'(p_r) + W1'(szp_r);
  assign last_step = (steps_r == STEP_W'(ARENA_UNITS + 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fla_pkg::ST_IDLE;
      rover_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    p_r        <= p_nxt;
    bp_r       <= bp_nxt;
    nx_r       <= nx_nxt;
    szp_r      <= szp_nxt;
    sznx_r     <= sznx_nxt;
    nxnx_r     <= nxnx_nxt;
    newsz_r    <= newsz_nxt;
    newnext_r  <= newnext_nxt;
    q_r        <= q_nxt;
    grant_r    <= grant_nxt;
    fail_r     <= fail_nxt;
    need_r     <= need_nxt;
    steps_r    <= steps_nxt;
    out_addr_r <= out_addr_nxt;
    out_fail_r <= out_fail_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    rover_nxt     = rover_r;
    prev_nxt      = prev_r;
    p_nxt         = p_r;
    bp_nxt        = bp_r;
    nx_nxt        = nx_r;
    szp_nxt       = szp_r;
    sznx_nxt      = sznx_r;
    nxnx_nxt      = nxnx_r;
    newsz_nxt     = newsz_r;
    newnext_nxt   = newnext_r;
    q_nxt         = q_r;
    grant_nxt     = grant_r;
    fail_nxt      = fail_r;
    need_nxt      = need_r;
    steps_nxt     = steps_r;
    out_addr_nxt  = out_addr_r;
    out_fail_nxt  = out_fail_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    req           = '0;
    req.rd_addr   = p_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      fla_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        req.rd_addr = rover_r;
        grant_nxt   = '0;
        fail_nxt    = 1'b0;
        steps_nxt   = '0;
        p_nxt       = rover_r;
        prev_nxt    = rover_r;
        if (in_valid) begin
          if (!operation) begin
            need_nxt  = fla_pkg::NEED_W'(prod >> SH) + fla_pkg::NEED_W'(1);
            state_nxt = fla_pkg::ST_A_FIRST;
          end else begin
            bp_nxt = block_address - fla_pkg::idx_t'(1);
            if (block_address < fla_pkg::idx_t'(2) ||
                (W1'(block_address) - W1'(1)) > W1'(ARENA_UNITS)) begin
              state_nxt = fla_pkg::ST_DONE;
            end else begin
              state_nxt = fla_pkg::ST_F_WALK;
            end
          end
        end
      end

      fla_pkg::ST_A_FIRST: begin
        p_nxt       = lk;
        req.rd_addr = lk;
        state_nxt   = fla_pkg::ST_A_WALK;
      end

      fla_pkg::ST_A_WALK: begin
        if (fla_pkg::NEED_W'(sz_rd) == need_r) begin
          req.nx_we    = 1'b1;
          req.nx_waddr = prev_r;
          req.nx_wdata = lk;
          rover_nxt    = prev_r;
          grant_nxt    = p_r + fla_pkg::idx_t'(1);
          state_nxt    = fla_pkg::ST_DONE;
        end else if (fla_pkg::NEED_W'(sz_rd) > need_r && qsum <= W1'(ARENA_UNITS)) begin
          req.sz_we    = 1'b1;
          req.sz_waddr = p_r;
          req.sz_wdata = rest;
          q_nxt        = fla_pkg::idx_t'(qsum);
          rover_nxt    = prev_r;
          grant_nxt    = fla_pkg::idx_t'(qsum) + fla_pkg::idx_t'(1);
          state_nxt    = fla_pkg::ST_A_SPLIT2;
        end else if (p_r == rover_r || last_step) begin
          fail_nxt  = 1'b1;
          state_nxt = fla_pkg::ST_DONE;
        end else begin
          prev_nxt    = p_r;
          p_nxt       = lk;
          req.rd_addr = lk;
          steps_nxt   = steps_r + STEP_W'(1);
        end
      end

      fla_pkg::ST_A_SPLIT2: begin
        req.sz_we    = 1'b1;
        req.sz_waddr = q_r;
        req.sz_wdata = fla_pkg::idx_t'(need_r);
        state_nxt    = fla_pkg::ST_DONE;
      end

      fla_pkg::ST_F_WALK: begin
        nx_nxt  = lk;
        szp_nxt = sz_rd;
        if ((bp_r > p_r && bp_r < lk) || (p_r >= lk && (bp_r > p_r || bp_r < lk))) begin
          req.rd_addr = lk;
          state_nxt   = fla_pkg::ST_F_RDNX;
        end else if (last_step) begin
          state_nxt = fla_pkg::ST_DONE;
        end else begin
          p_nxt       = lk;
          req.rd_addr = lk;
          steps_nxt   = steps_r + STEP_W'(1);
        end
      end

      fla_pkg::ST_F_RDNX: begin
        sznx_nxt    = sz_rd;
        nxnx_nxt    = lk;
        req.rd_addr = bp_r;
        state_nxt   = fla_pkg::ST_F_RDBP;
      end

      fla_pkg::ST_F_RDBP: begin
        if (upsum == W1'(nx_r)) begin
          newsz_nxt   = sz_rd + sznx_r;
          newnext_nxt = nxnx_r;
        end else begin
          newsz_nxt   = sz_rd;
          newnext_nxt = nx_r;
        end
        req.sz_we    = 1'b1;
        req.sz_waddr = bp_r;
        req.sz_wdata = newsz_nxt;
        req.nx_we    = 1'b1;
        req.nx_waddr = bp_r;
        req.nx_wdata = newnext_nxt;
        state_nxt    = fla_pkg::ST_F_LOWER;
      end

      fla_pkg::ST_F_LOWER: begin
        req.nx_we    = 1'b1;
        req.nx_waddr = p_r;
        if (losum == W1'(bp_r)) begin
          req.sz_we    = 1'b1;
          req.sz_waddr = p_r;
          req.sz_wdata = szp_r + newsz_r;
          req.nx_wdata = link(newnext_r);
        end else begin
          req.nx_wdata = bp_r;
        end
        rover_nxt = p_r;
        state_nxt = fla_pkg::ST_DONE;
      end

      fla_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = grant_r;
          out_fail_nxt  = fail_r;
          state_nxt     = fla_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fla_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign granted_address = out_addr_r;
  assign alloc_failed    = out_fail_r;

endmodule

// ----- sv/free_list_allocator_top.sv -----
// allocate: the rover's link is read, then the list is walked to a fit, one entry read
// per cycle, with an extra size write on a split; free: the list is walked to the
// insertion point, the next and freed headers are read, then the freed block and its
// lower neighbour are written, merged when adjacent; an out-of-range address goes
// to the result. One request at a time; the next is taken once the result is registered
// reset: synchronous active-low rst_n restores the free list and rover, no clearing pass
module free_list_allocator_top #(
  parameter int ARENA_UNITS  = fla_pkg::ARENA_UNITS_DEF,
  parameter int HEADER_BYTES = fla_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // operation, request_bytes, block_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // granted_address, alloc_failed
);

  fla_pkg::mem_req_t req;
  fla_pkg::idx_t     sz_rd;
  fla_pkg::idx_t     nx_rd;
  fla_pkg::idx_t     granted_address;
  logic              alloc_failed;

  fla_store #(
    .ARENA_UNITS (ARENA_UNITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .sz_rd (sz_rd),
    .nx_rd (nx_rd)
  );

  fla_ctrl #(
    .ARENA_UNITS  (ARENA_UNITS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .operation       (in_tdata[0]),
    .request_bytes   (in_tdata[16:1]),
    .block_address   (in_tdata[29:17]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .granted_address (granted_address),
    .alloc_failed    (alloc_failed),
    .req             (req),
    .sz_rd           (sz_rd),
    .nx_rd           (nx_rd)
  );

  assign out_tdata = {2'b00, alloc_failed, granted_address};

endmodule
